// ----- hw/rtl/rtt_pkg.sv -----
// Shared types and codes for the retry/timeout transaction controller.
// Used by rtt_step and retry_timeout_transaction_fsm_core; depends on nothing.
package rtt_pkg;

   // Event kinds carried on the request channel.
   localparam logic [1:0] FN_START    = 2'd0;
   localparam logic [1:0] FN_TICK     = 2'd1;
   localparam logic [1:0] FN_RESPONSE = 2'd2;
   localparam logic [1:0] FN_STOP     = 2'd3;

   // Response message types and NACK reasons.
   localparam logic [1:0] KIND_ACK         = 2'd0;
   localparam logic [1:0] KIND_NACK        = 2'd1;
   localparam logic [1:0] NACK_BUSY        = 2'd0;
   localparam logic [1:0] NACK_UNSUPPORTED = 2'd2;

   // Transaction phases.
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_WAIT_RESP  = 3'd1;
   localparam logic [2:0] PH_WAIT_RETRY = 3'd2;
   localparam logic [2:0] PH_SUCCEEDED  = 3'd3;
   localparam logic [2:0] PH_FAILED     = 3'd4;

   // Outcome codes reported with each result.
   localparam logic [2:0] OC_NONE      = 3'd0;
   localparam logic [2:0] OC_IGNORED   = 3'd1;
   localparam logic [2:0] OC_TIMEOUT   = 3'd2;
   localparam logic [2:0] OC_SUCCESS   = 3'd3;
   localparam logic [2:0] OC_REJECTED  = 3'd4;
   localparam logic [2:0] OC_EXHAUSTED = 3'd5;
   localparam logic [2:0] OC_STOPPED   = 3'd6;

   // Configuration register indexes.
   localparam logic [2:0] REG_RESPONSE_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_RETRY_DELAY      = 3'd1;
   localparam logic [2:0] REG_MAX_ATTEMPTS     = 3'd2;
   localparam logic [2:0] REG_TRANSACTION_ID   = 3'd3;
   localparam logic [2:0] REG_SERVICE_ID       = 3'd4;

   // Configuration reset values.
   localparam logic [31:0] RST_RESPONSE_TIMEOUT = 32'd500;
   localparam logic [31:0] RST_RETRY_DELAY      = 32'd250;
   localparam logic [7:0]  RST_MAX_ATTEMPTS     = 8'd3;
   localparam logic [31:0] RST_TRANSACTION_ID   = 32'd42;
   localparam logic [15:0] RST_SERVICE_ID       = 16'd0;

   // One event as held in the input register.
   typedef struct packed {
      logic [1:0]  func;
      logic        resp_frame_ok;
      logic [15:0] resp_service;
      logic [31:0] resp_txn;
      logic [1:0]  resp_kind;
      logic        resp_payload_ok;
      logic [1:0]  nack_code;
   } req_item_type;

   // One result as held in the output register.
   typedef struct packed {
      logic       send_request;
      logic [2:0] txn_state;
      logic [7:0] attempt_count;
      logic [2:0] outcome;
      logic       service_available;
      logic       done_res;
   } rsp_item_type;

   // Configuration values seen by the event logic.
   typedef struct packed {
      logic [31:0] response_timeout;
      logic [31:0] retry_delay;
      logic [7:0]  max_attempts;
      logic [31:0] transaction_id;
      logic [15:0] service_id;
   } cfg_type;

endpackage

// ----- hw/rtl/rtt_step.sv -----
// Next-state and result logic for one event of the transaction controller.
// Purely combinational; uses types and codes from rtt_pkg.
module rtt_step #(
   parameter int TIMER_WIDTH   = 32,
   parameter int ATTEMPT_WIDTH = 8
) (
   input  rtt_pkg::req_item_type     item,
   input  rtt_pkg::cfg_type          cfg,
   input  logic [2:0]                phase_ff,
   input  logic [ATTEMPT_WIDTH-1:0]  attempts_ff,
   input  logic [TIMER_WIDTH-1:0]    countdown_ff,
   input  logic                      armed_ff,
   input  logic                      avail_ff,
   input  logic                      stop_ff,
   output logic [2:0]                phase_in,
   output logic [ATTEMPT_WIDTH-1:0]  attempts_in,
   output logic [TIMER_WIDTH-1:0]    countdown_in,
   output logic                      armed_in,
   output logic                      avail_in,
   output logic                      stop_in,
   output rtt_pkg::rsp_item_type     result
);

   localparam logic [ATTEMPT_WIDTH-1:0] ATT_MAX = {ATTEMPT_WIDTH{1'b1}};
   localparam logic [TIMER_WIDTH-1:0]   CNT_ONE = TIMER_WIDTH'(1);

   logic [ATTEMPT_WIDTH-1:0]  att_inc;
   logic [ATTEMPT_WIDTH+7:0]  att_ext;
   logic [ATTEMPT_WIDTH+7:0]  max_ext;
   logic                      budget_used;
   logic                      resp_match;
   logic [ATTEMPT_WIDTH+7:0]  att_out;
   logic                      send;
   logic [2:0]                oc;

   // Saturating attempt increment and the budget check after a failed try.
   assign att_inc     = (attempts_ff < ATT_MAX) ? attempts_ff + 1'b1 : attempts_ff;
   assign att_ext     = {{8{1'b0}}, attempts_ff};
   assign max_ext     = {{ATTEMPT_WIDTH{1'b0}}, cfg.max_attempts};
   assign budget_used = (att_ext >= max_ext);

   // A response counts only in a waiting phase with matching header fields.
   assign resp_match = ((phase_ff == rtt_pkg::PH_WAIT_RESP) ||
                        (phase_ff == rtt_pkg::PH_WAIT_RETRY)) &&
                       item.resp_frame_ok &&
                       (item.resp_service == cfg.service_id) &&
                       (item.resp_txn == cfg.transaction_id);

   // Event decode.
   always_comb begin
      phase_in     = phase_ff;
      attempts_in  = attempts_ff;
      countdown_in = countdown_ff;
      armed_in     = armed_ff;
      avail_in     = avail_ff;
      stop_in      = stop_ff;
      send         = 1'b0;
      oc           = rtt_pkg::OC_NONE;
      if (!stop_ff) begin
         case (item.func)
            rtt_pkg::FN_START: begin
               if (phase_ff == rtt_pkg::PH_IDLE) begin
                  attempts_in  = att_inc;
                  send         = 1'b1;
                  countdown_in = cfg.response_timeout[TIMER_WIDTH-1:0];
                  armed_in     = 1'b1;
                  phase_in     = rtt_pkg::PH_WAIT_RESP;
               end
            end
            rtt_pkg::FN_TICK: begin
               if (armed_ff) begin
                  if (countdown_ff > CNT_ONE) begin
                     countdown_in = countdown_ff - CNT_ONE;
                  end else begin
                     countdown_in = '0;
                     armed_in     = 1'b0;
                     if (phase_ff == rtt_pkg::PH_WAIT_RESP) begin
                        // Response timeout: retry after a delay or give up.
                        if (budget_used) begin
                           avail_in = 1'b0;
                           phase_in = rtt_pkg::PH_FAILED;
                           stop_in  = 1'b1;
                           oc       = rtt_pkg::OC_EXHAUSTED;
                        end else begin
                           phase_in     = rtt_pkg::PH_WAIT_RETRY;
                           countdown_in = cfg.retry_delay[TIMER_WIDTH-1:0];
                           armed_in     = 1'b1;
                           oc           = rtt_pkg::OC_TIMEOUT;
                        end
                     end else if (phase_ff == rtt_pkg::PH_WAIT_RETRY) begin
                        // Retry delay over: resend.
                        attempts_in  = att_inc;
                        send         = 1'b1;
                        countdown_in = cfg.response_timeout[TIMER_WIDTH-1:0];
                        armed_in     = 1'b1;
                        phase_in     = rtt_pkg::PH_WAIT_RESP;
                     end
                  end
               end
            end
            rtt_pkg::FN_RESPONSE: begin
               oc = rtt_pkg::OC_IGNORED;
               if (resp_match) begin
                  if ((item.resp_kind == rtt_pkg::KIND_ACK) && item.resp_payload_ok) begin
                     countdown_in = '0;
                     armed_in     = 1'b0;
                     phase_in     = rtt_pkg::PH_SUCCEEDED;
                     stop_in      = 1'b1;
                     oc           = rtt_pkg::OC_SUCCESS;
                  end else if ((item.resp_kind == rtt_pkg::KIND_NACK) &&
                               item.resp_payload_ok &&
                               (item.nack_code <= rtt_pkg::NACK_UNSUPPORTED)) begin
                     countdown_in = '0;
                     armed_in     = 1'b0;
                     if (item.nack_code == rtt_pkg::NACK_BUSY) begin
                        // Busy: same retry decision as a timeout, quiet outcome.
                        if (budget_used) begin
                           avail_in = 1'b0;
                           phase_in = rtt_pkg::PH_FAILED;
                           stop_in  = 1'b1;
                           oc       = rtt_pkg::OC_EXHAUSTED;
                        end else begin
                           phase_in     = rtt_pkg::PH_WAIT_RETRY;
                           countdown_in = cfg.retry_delay[TIMER_WIDTH-1:0];
                           armed_in     = 1'b1;
                           oc           = rtt_pkg::OC_NONE;
                        end
                     end else begin
                        phase_in = rtt_pkg::PH_FAILED;
                        stop_in  = 1'b1;
                        oc       = rtt_pkg::OC_REJECTED;
                     end
                  end
               end
            end
            default: begin
               // Stop keeps the phase and disarms the timer.
               countdown_in = '0;
               armed_in     = 1'b0;
               stop_in      = 1'b1;
               oc           = rtt_pkg::OC_STOPPED;
            end
         endcase
      end
   end

   // Result fields reflect the state after the event.
   assign att_out = {{8{1'b0}}, attempts_in};

   always_comb begin
      result.send_request      = send;
      result.txn_state         = phase_in;
      result.attempt_count     = att_out[7:0];
      result.outcome           = oc;
      result.service_available = avail_in;
      result.done_res          = stop_in;
   end

endmodule

// ----- hw/rtl/retry_timeout_transaction_fsm_core.sv -----
// Request/retry transaction controller with response timeout: top level.
// Depends on rtt_pkg and rtt_step.
//
// Each event transfer on the req_ channel (start, tick, response or stop) yields exactly one
// result transfer on the rsp_ channel, in order. An event is captured in an input register,
// decoded by a single level of compare and countdown logic, and its result is registered in an
// output register, from which the result transfer is made. One event is taken every cycle
// while rsp_tready stays high. When a result waits with rsp_tready low, the input register
// still takes one more event and then req_tready drops until the waiting result is taken.
// Configuration registers are written through the csr_ port; the user must write them only
// while no event is in flight, which the block itself does not enforce.
module retry_timeout_transaction_fsm_core #(
   parameter int TIMER_WIDTH   = 32,
   parameter int ATTEMPT_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] resp_frame_ok, [16:1] resp_service, [48:17] resp_txn, [50:49] resp_kind,
   // [51] resp_payload_ok, [53:52] nack_code, [55:54] unused
   input  logic [55:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] send_request, [3:1] txn_state, [11:4] attempt_count, [14:12] outcome,
   // [15] service_available, [16] done_res, [23:17] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   rtt_pkg::cfg_type          cfg_ff;
   rtt_pkg::req_item_type     in_item_ff;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   rtt_pkg::rsp_item_type     out_item_ff;
   rtt_pkg::rsp_item_type     step_result;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      req_accept;
   logic                      advance;

   logic [2:0]                phase_ff;
   logic [2:0]                phase_in;
   logic [ATTEMPT_WIDTH-1:0]  attempts_ff;
   logic [ATTEMPT_WIDTH-1:0]  attempts_in;
   logic [TIMER_WIDTH-1:0]    countdown_ff;
   logic [TIMER_WIDTH-1:0]    countdown_in;
   logic                      armed_ff;
   logic                      armed_in;
   logic                      avail_ff;
   logic                      avail_in;
   logic                      stop_ff;
   logic                      stop_in;

   // Handshake: an event moves on when the output register is free or being emptied.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.response_timeout <= rtt_pkg::RST_RESPONSE_TIMEOUT;
         cfg_ff.retry_delay      <= rtt_pkg::RST_RETRY_DELAY;
         cfg_ff.max_attempts     <= rtt_pkg::RST_MAX_ATTEMPTS;
         cfg_ff.transaction_id   <= rtt_pkg::RST_TRANSACTION_ID;
         cfg_ff.service_id       <= rtt_pkg::RST_SERVICE_ID;
      end else if (csr_we) begin
         case (csr_index)
            rtt_pkg::REG_RESPONSE_TIMEOUT: cfg_ff.response_timeout <= csr_wdata;
            rtt_pkg::REG_RETRY_DELAY:      cfg_ff.retry_delay      <= csr_wdata;
            rtt_pkg::REG_MAX_ATTEMPTS:     cfg_ff.max_attempts     <= csr_wdata[7:0];
            rtt_pkg::REG_TRANSACTION_ID:   cfg_ff.transaction_id   <= csr_wdata;
            rtt_pkg::REG_SERVICE_ID:       cfg_ff.service_id       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.func            <= req_tuser;
         in_item_ff.resp_frame_ok   <= req_tdata[0];
         in_item_ff.resp_service    <= req_tdata[16:1];
         in_item_ff.resp_txn        <= req_tdata[48:17];
         in_item_ff.resp_kind       <= req_tdata[50:49];
         in_item_ff.resp_payload_ok <= req_tdata[51];
         in_item_ff.nack_code       <= req_tdata[53:52];
      end
   end

   // Event decode and next-state logic.
   rtt_step #(
      .TIMER_WIDTH   (TIMER_WIDTH),
      .ATTEMPT_WIDTH (ATTEMPT_WIDTH)
   ) u_step (
      .item         (in_item_ff),
      .cfg          (cfg_ff),
      .phase_ff     (phase_ff),
      .attempts_ff  (attempts_ff),
      .countdown_ff (countdown_ff),
      .armed_ff     (armed_ff),
      .avail_ff     (avail_ff),
      .stop_ff      (stop_ff),
      .phase_in     (phase_in),
      .attempts_in  (attempts_in),
      .countdown_in (countdown_in),
      .armed_in     (armed_in),
      .avail_in     (avail_in),
      .stop_in      (stop_in),
      .result       (step_result)
   );

   // Transaction state, updated when an event moves to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rtt_pkg::PH_IDLE;
         attempts_ff  <= '0;
         countdown_ff <= '0;
         armed_ff     <= 1'b0;
         avail_ff     <= 1'b1;
         stop_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         attempts_ff  <= attempts_in;
         countdown_ff <= countdown_in;
         armed_ff     <= armed_in;
         avail_ff     <= avail_in;
         stop_ff      <= stop_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_item_ff.done_res,
                        out_item_ff.service_available,
                        out_item_ff.outcome,
                        out_item_ff.attempt_count,
                        out_item_ff.txn_state,
                        out_item_ff.send_request};

endmodule
